### design/bbcw_pkg.sv
// Shared types and constants for the clipped box blur block.
// No dependencies; imported by every module of the block.
package bbcw_pkg;

  localparam int MAX_HALF_WINDOW = 8;
  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int RING_ROWS       = 2 * MAX_HALF_WINDOW;

  localparam int HW_W   = 4;                       // half window register
  localparam int DIM_W  = 11;                      // width / height registers
  localparam int COL_W  = 10;                      // pixel pointers
  localparam int RING_W = $clog2(RING_ROWS);
  localparam int ADDR_W = RING_W + COL_W;
  localparam int CNT_W  = $clog2(RING_ROWS * RING_ROWS + 1);
  localparam int SUM_W  = $clog2(RING_ROWS * RING_ROWS * 255 + 1);
  localparam int REM_W  = CNT_W + 1;
  localparam int DIVC_W = $clog2(SUM_W);
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_HALF_WINDOW  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic CMD_PUSH = 1'b0;

  typedef struct packed {
    logic [HW_W-1:0]  s;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic win_ready;
    logic win_empty;
    logic scan_last;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

endpackage

### design/bbcw_regs.sv
// APB configuration registers with clamped geometry outputs.
// Depends on bbcw_pkg.
module bbcw_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbcw_pkg::PADDR_W-1:0]    paddr,
  input  logic [bbcw_pkg::PDATA_W-1:0]    pwdata,
  output logic [bbcw_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output bbcw_pkg::cfg_t                  cfg_o
);
  import bbcw_pkg::*;

  logic [HW_W-1:0]  hw_q;
  logic [DIM_W-1:0] iw_q, ih_q;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_W'(1);
      iw_q <= DIM_W'(640);
      ih_q <= DIM_W'(480);
    end else if (wr_en) begin
      case (idx)
        REG_HALF_WINDOW:  hw_q <= pwdata[HW_W-1:0];
        REG_IMAGE_WIDTH:  iw_q <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: ih_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HALF_WINDOW:  prdata = PDATA_W'(hw_q);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(iw_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(ih_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.s = (hw_q == '0) ? HW_W'(1) :
              (hw_q > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : hw_q;
    cfg_o.w = (iw_q == '0) ? DIM_W'(1) :
              (iw_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : iw_q;
    cfg_o.h = (ih_q == '0) ? DIM_W'(1) :
              (ih_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : ih_q;
  end

endmodule

### design/bbcw_ctrl.sv
// Sequencer: accept, readiness check, window scan, divide, output load.
// Depends on bbcw_pkg.
module bbcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bbcw_pkg::dp_stat_t   stat_i,
  output bbcw_pkg::ctl_cmd_t   cmd_o
);
  import bbcw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat_i.win_ready) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = stat_i.win_empty ? ST_DSTART : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DSTART;   // last read lands in the sums
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### design/bbcw_datapath.sv
// Line store, pixel pointers, window accumulator, dividers, output register.
// Depends on bbcw_pkg.
module bbcw_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbcw_pkg::cfg_t       cfg_i,
  input  bbcw_pkg::ctl_cmd_t   cmd_i,
  output bbcw_pkg::dp_stat_t   stat_o,
  input  logic                 cmd_in_i,
  input  logic [7:0]           in_blue_i,
  input  logic [7:0]           in_green_i,
  input  logic [7:0]           in_red_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_red_o,
  output logic                 frame_end_o
);
  import bbcw_pkg::*;

  logic [23:0] store_mem [RING_ROWS * MAX_WIDTH];
  logic [23:0] rdata_q;
  logic        rd_vld_q;

  logic [COL_W-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
  logic             full_q;
  logic [COL_W-1:0] r_q, c_q;
  logic [CNT_W-1:0] n_q;
  logic [2:0][SUM_W-1:0] sum_q;
  logic [2:0][SUM_W-1:0] quo_q, quo_d;
  logic [2:0][REM_W-1:0] rem_q, rem_d;
  logic [DIVC_W-1:0]     divc_q;
  logic                  out_valid_q;
  logic [7:0]            ob_q, og_q, or_q;
  logic                  fe_q;

  logic             push;
  logic [DIM_W-1:0] rx, ry, x1, y1, w_m1, h_m1;
  logic [COL_W-1:0] x0, y0;
  logic             col_wrap, row_wrap, ocol_wrap, orow_wrap;
  logic [REM_W-1:0] rem_sh [3];

  assign push = cmd_i.accept && (cmd_in_i == CMD_PUSH) && !full_q;
  assign w_m1 = cfg_i.w - DIM_W'(1);
  assign h_m1 = cfg_i.h - DIM_W'(1);

  // window bounds for the next result
  always_comb begin
    rx = DIM_W'(out_col_q) + DIM_W'(cfg_i.s) - DIM_W'(1);
    ry = DIM_W'(out_row_q) + DIM_W'(cfg_i.s) - DIM_W'(1);
    x1 = (rx > w_m1) ? w_m1 : rx;
    y1 = (ry > h_m1) ? h_m1 : ry;
    x0 = (out_col_q >= COL_W'(cfg_i.s)) ? out_col_q - COL_W'(cfg_i.s) : '0;
    y0 = (out_row_q >= COL_W'(cfg_i.s)) ? out_row_q - COL_W'(cfg_i.s) : '0;
  end

  assign stat_o.win_ready = full_q || (y1 < DIM_W'(in_row_q)) ||
                            ((y1 == DIM_W'(in_row_q)) && (x1 < DIM_W'(in_col_q)));
  assign stat_o.win_empty = (DIM_W'(x0) > x1) || (DIM_W'(y0) > y1);
  assign stat_o.scan_last = (DIM_W'(c_q) == x1) && (DIM_W'(r_q) == y1);
  assign stat_o.div_done  = (divc_q == DIVC_W'(SUM_W - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign col_wrap  = (DIM_W'(in_col_q) + DIM_W'(1)) >= cfg_i.w;
  assign row_wrap  = (DIM_W'(in_row_q) + DIM_W'(1)) >= cfg_i.h;
  assign ocol_wrap = (DIM_W'(out_col_q) + DIM_W'(1)) >= cfg_i.w;
  assign orow_wrap = (DIM_W'(out_row_q) + DIM_W'(1)) >= cfg_i.h;

  // line store: one write at accept, one registered read during the scan
  always_ff @(posedge clk_i) begin
    if (push) store_mem[{in_row_q[RING_W-1:0], in_col_q}] <= {in_red_i, in_green_i, in_blue_i};
    rdata_q <= store_mem[{r_q[RING_W-1:0], c_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      full_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (push) begin
        if (col_wrap) begin
          in_col_q <= '0;
          if (row_wrap) begin
            in_row_q <= '0;
            full_q   <= 1'b1;
          end else begin
            in_row_q <= in_row_q + COL_W'(1);
          end
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (ocol_wrap) begin
          out_col_q <= '0;
          if (orow_wrap) begin
            out_row_q <= '0;
            full_q    <= 1'b0;
          end else begin
            out_row_q <= out_row_q + COL_W'(1);
          end
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per step, per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_q[i][REM_W-2:0], quo_q[i][SUM_W-1]};
      quo_d[i]  = {quo_q[i][SUM_W-2:0], 1'b0};
      rem_d[i]  = rem_sh[i];
      if (rem_sh[i] >= REM_W'(n_q)) begin
        rem_d[i]    = rem_sh[i] - REM_W'(n_q);
        quo_d[i][0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      r_q   <= y0;
      c_q   <= x0;
      n_q   <= '0;
      sum_q <= '0;
    end else begin
      if (cmd_i.scan_step) begin
        n_q <= n_q + CNT_W'(1);
        if (DIM_W'(c_q) == x1) begin
          c_q <= x0;
          r_q <= r_q + COL_W'(1);
        end else begin
          c_q <= c_q + COL_W'(1);
        end
      end
      if (rd_vld_q) begin
        for (int i = 0; i < 3; i++) sum_q[i] <= sum_q[i] + SUM_W'(rdata_q[8*i +: 8]);
      end
    end
    if (cmd_i.div_start) begin
      quo_q  <= sum_q;
      rem_q  <= '0;
      divc_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      divc_q <= divc_q + DIVC_W'(1);
    end
    if (cmd_i.out_load) begin
      ob_q <= (n_q == '0) ? 8'd0 : quo_q[0][7:0];
      og_q <= (n_q == '0) ? 8'd0 : quo_q[1][7:0];
      or_q <= (n_q == '0) ? 8'd0 : quo_q[2][7:0];
      fe_q <= ocol_wrap && orow_wrap;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = ob_q;
  assign out_green_o = og_q;
  assign out_red_o   = or_q;
  assign frame_end_o = fe_q;

endmodule

### design/box_blur_clipped_window.sv
// Top level of the clipped box blur: registers, sequencer and datapath.
// Depends on bbcw_pkg, bbcw_regs, bbcw_ctrl, bbcw_datapath.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one request per pixel in raster
//    order, cmd_i = 0 pushes the pixel, cmd_i = 1 is a drain tick. After the
//    last pixel of a frame, drain ticks flush the remaining results.
//  - Output channel (out_valid_o/out_ready_i): blurred pixel means in raster
//    order; frame_end_o marks the last result of the frame.
//  - APB port sets half window, width and height; write only while idle.
// Timing: a request that yields no result passes only accept and check.
//  A request that yields a result also scans the N in-image pixels of the
//  clipped window (N up to 256): the store has one read port, so the window
//  is summed one pixel a cycle, then a 16-step restoring divider runs for
//  all three channels at once.
// Reset: pointers and flags clear; the line store holds no valid data and
//  is only read where it was written. No clearing pass is needed.
// Stall: a result waits in the output register; the next request is still
//  accepted, and its result waits until that register is taken.
module box_blur_clipped_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbcw_pkg::PADDR_W-1:0]  paddr,
  input  logic [bbcw_pkg::PDATA_W-1:0]  pwdata,
  output logic [bbcw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_red_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_blue_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_red_o,
  output logic                          frame_end_o
);
  import bbcw_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // clamped geometry comes straight from the registers
  bbcw_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // one request at a time through accept / check / scan / divide / load
  bbcw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  bbcw_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i(cmd), .stat_o(stat),
    .cmd_in_i(cmd_i), .in_blue_i, .in_green_i, .in_red_i,
    .out_valid_o, .out_ready_i, .out_blue_o, .out_green_o, .out_red_o,
    .frame_end_o
  );

endmodule
